>>> sv/uart_lb_pkg.sv
package uart_lb_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// register offsets
	localparam logic [2:0] OFF_RBR = 3'd0;
	localparam logic [2:0] OFF_IER = 3'd1;
	localparam logic [2:0] OFF_IIR = 3'd2;
	localparam logic [2:0] OFF_LCR = 3'd3;
	localparam logic [2:0] OFF_MCR = 3'd4;
	localparam logic [2:0] OFF_LSR = 3'd5;
	localparam logic [2:0] OFF_MSR = 3'd6;
	localparam logic [2:0] OFF_SCR = 3'd7;

	// interrupt identification codes
	localparam logic [7:0] IIR_RX_LINE  = 8'h06;
	localparam logic [7:0] IIR_RX_DATA  = 8'h04;
	localparam logic [7:0] IIR_THR_EMPT = 8'h02;
	localparam logic [7:0] IIR_MODEM    = 8'h00;
	localparam logic [7:0] IIR_NONE     = 8'h01;
	localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;

	localparam logic [7:0] LSR_BASE    = 8'h60;
	localparam logic [7:0] LSR_DR      = 8'h01;
	localparam logic [7:0] LSR_OE      = 8'h02;
	localparam logic [7:0] MSR_FIXED   = 8'hB0;
	localparam logic [7:0] RX_EMPTY_RD = 8'hFF;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic       func;
		logic [2:0] reg_offset;
		logic [7:0] write_byte;
	} acc_t;

	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + ptr_t'(1);
		end
		return r;
	endfunction

endpackage

>>> sv/uart_lb_if.sv
interface uart_lb_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [2:0] reg_offset;
	logic [7:0] write_byte;

	modport source (output valid, output func, output reg_offset, output write_byte,
		input ready);
	modport sink (input valid, input func, input reg_offset, input write_byte,
		output ready);
endinterface

interface uart_lb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;

	modport source (output valid, output read_byte, input ready);
	modport sink (input valid, input read_byte, output ready);
endinterface

>>> sv/uart_lb_regs.sv
module uart_lb_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc_valid,
	input  uart_lb_pkg::acc_t acc,
	output logic [7:0]        rd_byte
);

	logic [7:0]        fifo_mem [uart_lb_pkg::FIFO_DEPTH];
	uart_lb_pkg::ptr_t wptr_q;
	uart_lb_pkg::ptr_t rptr_q;
	uart_lb_pkg::cnt_t fill_q;
	logic              ovr_q;
	logic [15:0]       dl_q;
	logic [7:0]        fcr_q;
	logic [3:0]        trig_q;
	logic [3:0]        ier_q;
	logic [7:0]        lcr_q;
	logic [7:0]        mcr_q;
	logic [7:0]        scr_q;

	logic       is_rd;
	logic       is_wr;
	logic       dl_sel;
	logic       empty;
	logic       full;
	logic       push;
	logic       push_ok;
	logic       pop;
	logic       fifo_clr;
	logic [7:0] iir;
	logic [7:0] lsr;
	logic [7:0] rd_data;
	logic [3:0] trig_new;

	assign is_rd  = acc_valid && (acc.func == uart_lb_pkg::FUNC_READ);
	assign is_wr  = acc_valid && (acc.func == uart_lb_pkg::FUNC_WRITE);
	// divisor latch access bit redirects the two lowest offsets
	assign dl_sel = lcr_q[7] && ((acc.reg_offset == uart_lb_pkg::OFF_RBR) ||
		(acc.reg_offset == uart_lb_pkg::OFF_IER));
	assign empty  = (fill_q == '0);
	assign full   = (fill_q == uart_lb_pkg::CNT_W'(uart_lb_pkg::FIFO_DEPTH));

	assign push     = is_wr && !dl_sel && (acc.reg_offset == uart_lb_pkg::OFF_RBR);
	assign push_ok  = push && !full;
	assign pop      = is_rd && !dl_sel && (acc.reg_offset == uart_lb_pkg::OFF_RBR) && !empty;
	assign fifo_clr = is_wr && (acc.reg_offset == uart_lb_pkg::OFF_IIR) &&
		(acc.write_byte[2:1] != 2'b00);

	always_comb begin
		priority if (ier_q[2] && ovr_q) begin
			iir = uart_lb_pkg::IIR_RX_LINE;
		end else if (ier_q[0] && (fill_q >= uart_lb_pkg::CNT_W'(trig_q))) begin
			iir = uart_lb_pkg::IIR_RX_DATA;
		end else if (ier_q[1]) begin
			iir = uart_lb_pkg::IIR_THR_EMPT;
		end else if (ier_q[3] && (mcr_q[1:0] != 2'b00)) begin
			iir = uart_lb_pkg::IIR_MODEM;
		end else begin
			iir = uart_lb_pkg::IIR_NONE;
		end
		if (fcr_q[0]) begin
			iir = iir | uart_lb_pkg::IIR_FIFO_ON;
		end
	end

	always_comb begin
		lsr = uart_lb_pkg::LSR_BASE;
		if (!empty) begin
			lsr = lsr | uart_lb_pkg::LSR_DR;
		end
		if (ovr_q) begin
			lsr = lsr | uart_lb_pkg::LSR_OE;
		end
	end

	always_comb begin
		if (dl_sel) begin
			rd_data = (acc.reg_offset == uart_lb_pkg::OFF_RBR) ? dl_q[7:0] : dl_q[15:8];
		end else begin
			unique case (acc.reg_offset)
				uart_lb_pkg::OFF_RBR: begin
					rd_data = empty ? uart_lb_pkg::RX_EMPTY_RD : fifo_mem[rptr_q];
				end
				uart_lb_pkg::OFF_IER: rd_data = {4'h0, ier_q};
				uart_lb_pkg::OFF_IIR: rd_data = iir;
				uart_lb_pkg::OFF_LCR: rd_data = lcr_q;
				uart_lb_pkg::OFF_MCR: rd_data = mcr_q;
				uart_lb_pkg::OFF_LSR: rd_data = lsr;
				uart_lb_pkg::OFF_MSR: rd_data = uart_lb_pkg::MSR_FIXED;
				default:              rd_data = scr_q;
			endcase
		end
	end

	assign rd_byte = is_rd ? rd_data : 8'h00;

	always_comb begin
		unique case (acc.write_byte[7:6])
			2'b00:   trig_new = 4'd1;
			2'b01:   trig_new = 4'd4;
			2'b10:   trig_new = 4'd8;
			default: trig_new = 4'd14;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_mem[wptr_q] <= acc.write_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
			ovr_q  <= 1'b0;
			dl_q   <= '0;
			fcr_q  <= '0;
			trig_q <= 4'd1;
			ier_q  <= '0;
			lcr_q  <= '0;
			mcr_q  <= '0;
			scr_q  <= '0;
		end else if (is_wr) begin
			if (dl_sel) begin
				if (acc.reg_offset == uart_lb_pkg::OFF_RBR) begin
					dl_q[7:0] <= acc.write_byte;
				end else begin
					dl_q[15:8] <= acc.write_byte;
				end
			end else begin
				unique case (acc.reg_offset)
					uart_lb_pkg::OFF_RBR: begin
						if (full) begin
							ovr_q <= 1'b1;
						end else begin
							wptr_q <= uart_lb_pkg::ptr_next(wptr_q);
							fill_q <= fill_q + uart_lb_pkg::cnt_t'(1);
							ovr_q  <= 1'b0;
						end
					end
					uart_lb_pkg::OFF_IER: ier_q <= acc.write_byte[3:0];
					uart_lb_pkg::OFF_IIR: begin
						fcr_q  <= acc.write_byte;
						trig_q <= trig_new;
						if (fifo_clr) begin
							wptr_q <= '0;
							rptr_q <= '0;
							fill_q <= '0;
							ovr_q  <= 1'b0;
						end
					end
					uart_lb_pkg::OFF_LCR: lcr_q <= acc.write_byte;
					uart_lb_pkg::OFF_MCR: mcr_q <= acc.write_byte;
					uart_lb_pkg::OFF_SCR: scr_q <= acc.write_byte;
					default: begin
						// status registers are read only
					end
				endcase
			end
		end else if (pop) begin
			rptr_q <= uart_lb_pkg::ptr_next(rptr_q);
			fill_q <= fill_q - uart_lb_pkg::cnt_t'(1);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= uart_lb_pkg::CNT_W'(uart_lb_pkg::FIFO_DEPTH))
		else $error("rx fill count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> (fill_q == $past(fill_q) + uart_lb_pkg::cnt_t'(1)) && !ovr_q)
		else $error("push did not advance fill count");

	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |=> ovr_q && (fill_q == $past(fill_q)))
		else $error("push into full fifo did not flag overrun");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_clr |=> (fill_q == '0) && (wptr_q == '0) && (rptr_q == '0) && !ovr_q)
		else $error("fifo clear incomplete");

endmodule

>>> sv/uart_lb_outq.sv
module uart_lb_outq (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte
);

	logic [7:0] data_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_byte  = data_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q ^ rd_q) == count_q[0])
		else $error("output queue pointers disagree with count");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && (out_byte == $past(out_byte)))
		else $error("waiting result lost");

endmodule

>>> sv/uart_16550_loopback_registers_top.sv
// Loopback 16550-style UART register window. Each request item is one read or write at a
// 3-bit offset and yields exactly one response item (the register value on a read, zero on a
// write). Items are taken at one per cycle while ready is high: the access is decoded and
// the register file and 16-entry receive FIFO are updated at the accepting clock edge, and
// the result enters a two-slot output queue and is offered on the response channel in order.
// Request ready drops only while both queue slots hold results that have not been taken.
// No clearing pass follows reset; FIFO contents are only read after they have been written.
module uart_16550_loopback_registers_top (
	input  logic              clk,
	input  logic              arst_n,
	uart_lb_req_if.sink       req,
	uart_lb_rsp_if.source     rsp
);

	uart_lb_pkg::acc_t acc;
	logic              q_ready;
	logic              accept;
	logic [7:0]        rd_byte;

	assign acc.func       = req.func;
	assign acc.reg_offset = req.reg_offset;
	assign acc.write_byte = req.write_byte;
	assign req.ready      = q_ready;
	assign accept         = req.valid && q_ready;

	uart_lb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (accept),
		.acc       (acc),
		.rd_byte   (rd_byte)
	);

	uart_lb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (q_ready),
		.in_byte   (rd_byte),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_byte  (rsp.read_byte)
	);

endmodule
